[rtl/assert_macros.svh]
// assertion macros for the checker file bbc_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside of reset
`define BBC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// property that must also hold while reset is applied
`define BBC_ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[rtl/bbc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and constants of the bracket balance checker.
// ----------------------------------------------------------------------------
package bbc_pkg;

    localparam int STACK_DEPTH_DEFAULT = 128;

    // classification queue between front and back end
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // bracket characters
    localparam logic [7:0] CHAR_OPEN_PAREN    = 8'h28;
    localparam logic [7:0] CHAR_OPEN_SQUARE   = 8'h5B;
    localparam logic [7:0] CHAR_OPEN_CURLY    = 8'h7B;
    localparam logic [7:0] CHAR_CLOSE_PAREN   = 8'h29;
    localparam logic [7:0] CHAR_CLOSE_SQUARE  = 8'h5D;
    localparam logic [7:0] CHAR_CLOSE_CURLY   = 8'h7D;

    // bracket kinds kept on the stack
    localparam logic [1:0] KIND_PAREN  = 2'd0;
    localparam logic [1:0] KIND_SQUARE = 2'd1;
    localparam logic [1:0] KIND_CURLY  = 2'd2;

    // verdict and sticky failure codes
    localparam logic [1:0] VERDICT_BALANCED   = 2'd0;
    localparam logic [1:0] VERDICT_UNBALANCED = 2'd1;
    localparam logic [1:0] VERDICT_OVERFLOW   = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_OPEN,
        OP_CLOSE
    } op_kind_t;

    typedef struct packed {
        op_kind_t   op;
        logic [1:0] kind;
        logic       last;
    } bbc_entry_t;

endpackage

[rtl/bbc_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_queue
// Small first-in first-out queue of classified bytes.
// ----------------------------------------------------------------------------
module bbc_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_valid,
    input  bbc_pkg::bbc_entry_t wr_data,
    output logic               full,
    output logic               rd_valid,
    input  logic               rd_ready,
    output bbc_pkg::bbc_entry_t rd_data
);
    import bbc_pkg::*;

    bbc_entry_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg;
    logic [QCNT_W-1:0]  cnt_next;
    logic               do_wr;
    logic               do_rd;

    assign full     = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && !full;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/bbc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_front
// Input side: takes byte transfers and classifies them into stack operations.
// ----------------------------------------------------------------------------
module bbc_front (
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_char_code,
    input  logic                s_is_last,
    input  logic                q_full,
    output logic                q_wr_valid,
    output bbc_pkg::bbc_entry_t q_wr_data
);
    import bbc_pkg::*;

    assign s_ready    = !q_full;
    assign q_wr_valid = s_valid;

    always_comb begin
        q_wr_data.op   = OP_NONE;
        q_wr_data.kind = KIND_PAREN;
        q_wr_data.last = s_is_last;
        case (s_char_code)
            CHAR_OPEN_PAREN: begin
                q_wr_data.op   = OP_OPEN;
                q_wr_data.kind = KIND_PAREN;
            end
            CHAR_OPEN_SQUARE: begin
                q_wr_data.op   = OP_OPEN;
                q_wr_data.kind = KIND_SQUARE;
            end
            CHAR_OPEN_CURLY: begin
                q_wr_data.op   = OP_OPEN;
                q_wr_data.kind = KIND_CURLY;
            end
            CHAR_CLOSE_PAREN: begin
                q_wr_data.op   = OP_CLOSE;
                q_wr_data.kind = KIND_PAREN;
            end
            CHAR_CLOSE_SQUARE: begin
                q_wr_data.op   = OP_CLOSE;
                q_wr_data.kind = KIND_SQUARE;
            end
            CHAR_CLOSE_CURLY: begin
                q_wr_data.op   = OP_CLOSE;
                q_wr_data.kind = KIND_CURLY;
            end
            default: begin
                q_wr_data.op = OP_NONE;
            end
        endcase
    end

endmodule

[rtl/bbc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_back
// Execution side: runs the bracket stack and produces the verdict.
// ----------------------------------------------------------------------------
module bbc_back #(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  bbc_pkg::bbc_entry_t q_data,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_verdict
);
    import bbc_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // top of stack lives in top_reg, the entry below it in second_reg,
    // everything deeper in stack_mem
    logic [1:0]    stack_mem [STACK_DEPTH];
    logic [1:0]    top_reg;
    logic [1:0]    top_next;
    logic [1:0]    second_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [1:0]    fail_reg;
    logic [1:0]    fail_next;
    logic          m_valid_reg;
    logic [1:0]    m_verdict_reg;
    logic [1:0]    verdict_next;

    logic          take;
    logic          active;
    logic          full;
    logic          empty;
    logic          do_push;
    logic          do_pop;
    logic          overflow;
    logic          underflow;
    logic          mismatch;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    // a last item needs the output register free, other items never wait
    assign take    = q_valid && (!q_data.last || !m_valid_reg || m_ready);
    assign q_ready = take;
    assign active  = take && (fail_reg == VERDICT_BALANCED);

    assign full  = (count_reg == CW'(STACK_DEPTH));
    assign empty = (count_reg == '0);

    assign do_push   = active && (q_data.op == OP_OPEN) && !full;
    assign overflow  = active && (q_data.op == OP_OPEN) && full;
    assign do_pop    = active && (q_data.op == OP_CLOSE) && !empty;
    assign underflow = active && (q_data.op == OP_CLOSE) && empty;
    assign mismatch  = do_pop && (top_reg != q_data.kind);

    // entry i sits in stack_mem[i] once something is pushed above it; a pop
    // refills second_reg with the entry two below the old top
    assign wr_addr = AW'(count_reg - CW'(1));
    assign rd_addr = AW'(count_reg - CW'(3));

    always_comb begin
        fail_next = fail_reg;
        if (overflow) begin
            fail_next = VERDICT_OVERFLOW;
        end else if (underflow || mismatch) begin
            fail_next = VERDICT_UNBALANCED;
        end

        count_next = count_reg;
        top_next   = top_reg;
        if (do_push) begin
            count_next = count_reg + CW'(1);
            top_next   = q_data.kind;
        end else if (do_pop) begin
            count_next = count_reg - CW'(1);
            top_next   = second_reg;
        end

        if (fail_next != VERDICT_BALANCED) begin
            verdict_next = fail_next;
        end else if (count_next != '0) begin
            verdict_next = VERDICT_UNBALANCED;
        end else begin
            verdict_next = VERDICT_BALANCED;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            fail_reg    <= VERDICT_BALANCED;
            m_valid_reg <= 1'b0;
        end else begin
            if (take && q_data.last) begin
                count_reg   <= '0;
                fail_reg    <= VERDICT_BALANCED;
                m_valid_reg <= 1'b1;
            end else begin
                count_reg <= count_next;
                fail_reg  <= fail_next;
                if (m_ready) begin
                    m_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        top_reg <= top_next;
        if (take && q_data.last) begin
            m_verdict_reg <= verdict_next;
        end
    end

    // spill old top to memory and copy it into second_reg on push, refill second from memory on pop
    always_ff @(posedge aclk) begin
        if (do_push && !empty) begin
            stack_mem[wr_addr] <= top_reg;
        end
        if (do_pop) begin
            second_reg <= stack_mem[rd_addr];
        end else if (do_push) begin
            second_reg <= top_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_verdict = m_verdict_reg;

endmodule

[rtl/bracket_balance_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_balance_checker
// Checks a byte stream for balanced ( [ { brackets and reports one verdict.
// ----------------------------------------------------------------------------
// One byte transfer is taken per clock while the 4-entry classification queue
// has room; the stack unit retires one byte per clock unless a last byte is
// held back, since a push or pop only touches the top register, a spill/refill
// register and one port of the STACK_DEPTH-entry stack memory. A verdict
// (0 balanced, 1 not balanced, 2 stack overflow) is registered onto m_verdict
// as the last byte leaves the queue; that byte waits in the queue only while
// an earlier verdict is still held in the output register. State clears
// after every last byte, so streams follow each other with no gap.
module bracket_balance_checker #(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    input  logic       s_is_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_verdict
);
    import bbc_pkg::*;

    logic       q_full;
    logic       q_wr_valid;
    bbc_entry_t q_wr_data;
    logic       q_rd_valid;
    logic       q_rd_ready;
    bbc_entry_t q_rd_data;

    bbc_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .s_is_last   (s_is_last),
        .q_full      (q_full),
        .q_wr_valid  (q_wr_valid),
        .q_wr_data   (q_wr_data)
    );

    bbc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (q_wr_valid),
        .wr_data  (q_wr_data),
        .full     (q_full),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_data  (q_rd_data)
    );

    bbc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_rd_valid),
        .q_ready   (q_rd_ready),
        .q_data    (q_rd_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_verdict (m_verdict)
    );

endmodule

[rtl/bbc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_checker
// Port-level checks of the result channel of the bracket balance checker.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bbc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_verdict
);
    import bbc_pkg::*;

    `BBC_ASSERT_RST(a_idle_after_reset, !aresetn |=> !m_valid, "result valid right after reset")
    `BBC_ASSERT(a_verdict_code, m_valid |-> (m_verdict == VERDICT_BALANCED || m_verdict == VERDICT_UNBALANCED || m_verdict == VERDICT_OVERFLOW), "verdict code out of range")
    `BBC_ASSERT(a_valid_holds, m_valid && !m_ready |=> m_valid, "result dropped before transfer")
    `BBC_ASSERT(a_verdict_holds, m_valid && !m_ready |=> $stable(m_verdict), "verdict changed while stalled")

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (.*);
